// ===== rtl/core/pse_pkg.sv =====
// Shared types and constants of the piecewise spline evaluator.
`default_nettype none
package pse_pkg;
  localparam int MaxKnotsDef = 16;
  localparam int FracBitsDef = 16;
  localparam int DataW = 32;
  localparam int CountW = 5;
  localparam int KindW = 2;
  localparam int EntryW = 4;

  localparam logic [0:0] CfgKnotCount = 1'b0;
  localparam logic [0:0] CfgInterpKind = 1'b1;

  localparam logic [KindW-1:0] KindConst = 2'd0;
  localparam logic [KindW-1:0] KindLinear = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_SEARCH, ST_PREP, ST_DIV, ST_MUL1, ST_MUL2,
    ST_MUL3, ST_SUM, ST_OUT
  } pse_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic rd_step;
    logic check_step;
    logic search_step;
    logic prep;
    logic div_step;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sum;
    logic finish;
  } pse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic bad;
    logic edge_case;
    logic div_done;
  } pse_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/piecewise_spline_evaluator_unit.sv =====
// Top level of the piecewise spline evaluator.
`default_nettype none
// Evaluates a loaded knot table at a query time. A load word (mode 0)
// writes one table entry and gives no result. An evaluate word (mode 1)
// produces one result word: the controller checks that knot times rise
// strictly and then finds the interval, one table entry a cycle each,
// runs a one-bit-a-cycle restoring divider for the blend fraction and
// four multiply steps. The divider and multiply steps are skipped at the
// table ends, and an invalid table skips the search as well. One word is
// in work at a time: no new word is taken until the result has gone into
// the output register.
// The result sits in an output register until taken, and the next input
// word is accepted while it waits.
module piecewise_spline_evaluator_unit import pse_pkg::*; #(
  parameter int MaxKnots = MaxKnotsDef,
  parameter int FracBits = FracBitsDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [0:0]              cfg_index,
  input  wire logic [CountW-1:0]       cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_mode,
  input  wire logic [EntryW-1:0]       in_entry_index,
  input  wire logic signed [DataW-1:0] in_knot_time,
  input  wire logic signed [DataW-1:0] in_knot_value,
  input  wire logic signed [DataW-1:0] in_control_one,
  input  wire logic signed [DataW-1:0] in_control_two,
  input  wire logic signed [DataW-1:0] in_query_time,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [DataW-1:0]      out_curve_value,
  output logic                         out_table_invalid
);
  logic [CountW-1:0] knot_count_r;
  logic [KindW-1:0] interp_kind_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= CountW'(1);
      interp_kind_r <= KindLinear;
    end else if (cfg_we) begin
      if (cfg_index == CfgKnotCount) knot_count_r <= cfg_data;
      else interp_kind_r <= cfg_data[KindW-1:0];
    end
  end

  pse_cmd_t cmd;
  pse_sts_t sts;
  logic busy, res_load, acc, out_free;
  logic signed [DataW-1:0] res_value;
  logic res_bad;

  assign in_stall = busy;
  assign acc = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  pse_ctrl u_ctrl (
    .clk, .rst_n, .go(acc && in_mode), .out_free, .sts, .cmd, .busy, .res_load
  );

  pse_dp #(.MaxKnots(MaxKnots), .FracBits(FracBits)) u_dp (
    .clk, .cmd, .load_en(acc && !in_mode), .load_idx(in_entry_index),
    .load_time(in_knot_time), .load_value(in_knot_value),
    .load_c1(in_control_one), .load_c2(in_control_two), .query(in_query_time),
    .knot_count(knot_count_r), .interp_kind(interp_kind_r), .sts,
    .res_value, .res_bad
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (res_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (res_load) begin
      out_curve_value <= res_value;
      out_table_invalid <= res_bad;
    end
  end

  // A flagged table always reports a zero value.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res_bad |=> out_curve_value == '0) else $error("bad table nonzero");
  // No new word starts while the controller works.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !acc) else $error("accepted while busy");
  // A result is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free) else $error("result overwritten");
endmodule
`default_nettype wire

// ===== rtl/core/pse_ctrl.sv =====
// Controller state machine for the spline evaluator.
`default_nettype none
module pse_ctrl import pse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     go,
  input  wire logic     out_free,
  input  pse_sts_t      sts,
  output pse_cmd_t      cmd,
  output logic          busy,
  output logic          res_load
);
  pse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    res_load = 1'b0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (go) begin
          cmd.start = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check_step = 1'b1;
        if (sts.scan_done) state_nxt = sts.bad ? ST_OUT : ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (sts.scan_done) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = sts.edge_case ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3 = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          res_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/pse_dp.sv =====
// Datapath of the spline evaluator: knot table, search, divider, blends.
`default_nettype none
module pse_dp import pse_pkg::*; #(
  parameter int MaxKnots = MaxKnotsDef,
  parameter int FracBits = FracBitsDef
) (
  input  wire logic                    clk,
  input  pse_cmd_t                     cmd,
  input  wire logic                    load_en,
  input  wire logic [EntryW-1:0]       load_idx,
  input  wire logic signed [DataW-1:0] load_time,
  input  wire logic signed [DataW-1:0] load_value,
  input  wire logic signed [DataW-1:0] load_c1,
  input  wire logic signed [DataW-1:0] load_c2,
  input  wire logic signed [DataW-1:0] query,
  input  wire logic [CountW-1:0]       knot_count,
  input  wire logic [KindW-1:0]        interp_kind,
  output pse_sts_t                     sts,
  output logic signed [DataW-1:0]      res_value,
  output logic                         res_bad
);
  localparam int IdxW = $clog2(MaxKnots);
  localparam int CntW = $clog2(MaxKnots + 1);
  localparam int FW = FracBits + 1;
  localparam int DivW = DataW + 1;
  localparam int DcW = $clog2(FracBits + DivW + 1);
  localparam int ProdW = DataW + FW + 1;
  localparam int AccW = ProdW + 3;
  localparam logic [FW-1:0] Scale = FW'(1) << FracBits;

  logic signed [DataW-1:0] t_mem [MaxKnots];
  logic signed [DataW-1:0] v_mem [MaxKnots];
  logic signed [DataW-1:0] c1_mem [MaxKnots];
  logic signed [DataW-1:0] c2_mem [MaxKnots];

  always_ff @(posedge clk) begin
    if (load_en && (32'(load_idx) < MaxKnots)) begin
      t_mem[IdxW'(load_idx)] <= load_time;
      v_mem[IdxW'(load_idx)] <= load_value;
      c1_mem[IdxW'(load_idx)] <= load_c1;
      c2_mem[IdxW'(load_idx)] <= load_c2;
    end
  end

  logic [CntW-1:0] n;
  assign n = (32'(knot_count) > MaxKnots) ? CntW'(MaxKnots) : CntW'(knot_count);

  // Scan pointer walks the table one entry a cycle.
  logic [CntW-1:0] ptr_r;
  logic signed [DataW-1:0] prev_t_r, cur_t;
  logic bad_r;
  logic signed [DataW-1:0] q_r, t0_r, t1_r, v0_r, v1_r, c1_r, c2_r;
  logic [CntW-1:0] idx;

  // Restoring divider, one quotient bit per cycle.
  logic [DcW-1:0] div_cnt_r;
  logic [DivW-1:0] den_r, rem_r;
  logic [DivW+FracBits-1:0] num_r;
  logic [FW-1:0] quo_r;
  logic [DivW:0] rem_sh;

  assign cur_t = t_mem[ptr_r[IdxW-1:0]];
  assign idx = ptr_r;

  always_comb begin
    sts = '0;
    sts.bad = bad_r;
    if (cmd.check_step) sts.scan_done = (ptr_r >= n) || bad_r ||
        ((ptr_r != '0) && (cur_t <= prev_t_r));
    if (cmd.search_step) sts.scan_done = (ptr_r >= n) || (cur_t > q_r);
    if (cmd.check_step && (ptr_r < n) && (ptr_r != '0) && (cur_t <= prev_t_r))
      sts.bad = 1'b1;
    sts.edge_case = (idx == '0) || (idx >= n);
    // The first step loads the divisor, then every numerator bit is consumed.
    sts.div_done = div_cnt_r == DcW'(FracBits + DivW);
  end

  assign rem_sh = {rem_r, num_r[DivW+FracBits-1]};

  logic [FW-1:0] f_c, u_c;
  assign f_c = (quo_r >= Scale) ? Scale - FW'(1) : quo_r;
  assign u_c = Scale - f_c;

  logic [FW-1:0] f_r, u_r, uu_r, ff_r;
  logic [FW-1:0] b0_r, b1_r, b2_r, b3_r;
  logic signed [ProdW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [AccW-1:0] acc, rnd;
  logic [2*FW-1:0] m_a, m_b, m_c, m_d;

  always_comb begin
    m_a = u_r * u_r; m_b = f_r * f_r; m_c = '0; m_d = '0;
    if (cmd.mul3) begin
      m_a = uu_r * u_r; m_b = uu_r * f_r; m_c = u_r * ff_r; m_d = ff_r * f_r;
    end
  end

  assign acc = AccW'(p0_r) + AccW'(p1_r) + AccW'(p2_r) + AccW'(p3_r);
  assign rnd = (acc + (AccW'(1) <<< (FracBits - 1))) >>> FracBits;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr_r <= '0;
      bad_r <= (n == '0);
      q_r <= query;
    end
    if (cmd.check_step) begin
      if (sts.bad) bad_r <= 1'b1;
      prev_t_r <= cur_t;
      ptr_r <= sts.scan_done ? '0 : ptr_r + CntW'(1);
    end
    if (cmd.search_step && !sts.scan_done) ptr_r <= ptr_r + CntW'(1);
    if (cmd.prep) begin
      if (idx == '0) begin
        v0_r <= v_mem[0];
      end else if (idx >= n) begin
        v0_r <= v_mem[IdxW'(n - CntW'(1))];
      end else begin
        v0_r <= v_mem[IdxW'(idx - CntW'(1))];
        c1_r <= c1_mem[IdxW'(idx - CntW'(1))];
        c2_r <= c2_mem[IdxW'(idx - CntW'(1))];
        v1_r <= v_mem[idx[IdxW-1:0]];
        t0_r <= t_mem[IdxW'(idx - CntW'(1))];
        t1_r <= t_mem[idx[IdxW-1:0]];
        num_r <= {DivW'(q_r) - DivW'(t_mem[IdxW'(idx - CntW'(1))]), FracBits'(0)};
      end
      den_r <= '0;
      rem_r <= '0;
      div_cnt_r <= '0;
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      if (div_cnt_r == '0) den_r <= DivW'(t1_r) - DivW'(t0_r);
      else begin
        num_r <= num_r << 1;
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= DivW'(rem_sh - {1'b0, den_r});
          quo_r <= {quo_r[FW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DivW-1:0];
          quo_r <= {quo_r[FW-2:0], 1'b0};
        end
      end
      div_cnt_r <= div_cnt_r + DcW'(1);
    end
    if (cmd.mul1) begin
      f_r <= f_c;
      u_r <= u_c;
    end
    if (cmd.mul2) begin
      uu_r <= FW'(m_a >> FracBits);
      ff_r <= FW'(m_b >> FracBits);
    end
    if (cmd.mul3) begin
      if (interp_kind == KindLinear) begin
        p0_r <= ProdW'(v0_r * $signed({1'b0, u_r}));
        p1_r <= ProdW'(v1_r * $signed({1'b0, f_r}));
        p2_r <= '0;
        p3_r <= '0;
      end else begin
        b0_r <= FW'(m_a >> FracBits);
        b1_r <= FW'(m_b >> FracBits);
        b2_r <= FW'(m_c >> FracBits);
        b3_r <= FW'(m_d >> FracBits);
      end
    end
    if (cmd.sum && interp_kind != KindLinear) begin
      p0_r <= ProdW'(v0_r * $signed({1'b0, b0_r}));
      p1_r <= ProdW'(c1_r * $signed({1'b0, b1_r})) * ProdW'(3);
      p2_r <= ProdW'(c2_r * $signed({1'b0, b2_r})) * ProdW'(3);
      p3_r <= ProdW'(v1_r * $signed({1'b0, b3_r}));
    end
  end

  // Linear products land in mul3, cubic in sum; result formed at output time.
  logic blend_r;
  always_ff @(posedge clk) begin
    if (cmd.prep) blend_r <= !sts.edge_case && (interp_kind != KindConst);
  end

  always_comb begin
    res_bad = bad_r;
    if (bad_r) res_value = '0;
    else if (!blend_r) res_value = v0_r;
    else if (rnd > AccW'(32'sh7fffffff)) res_value = 32'sh7fffffff;
    else if (rnd < -AccW'(33'sh080000000)) res_value = 32'sh80000000;
    else res_value = DataW'(rnd);
  end
endmodule
`default_nettype wire

// ===== sim/tb_piecewise_spline_evaluator_unit.sv =====
// Self-checking testbench of the piecewise spline evaluator top level.
`default_nettype none
module tb_piecewise_spline_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  // The package names only the constant and linear kinds.
  localparam logic [KindW-1:0] KindCubic = 2'd2;
  localparam logic [KindW-1:0] KindSpare = 2'd3;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEval = 1'b1;
  // Idle stretch that settle() adds once every expected result is back.
  localparam int SettleCycles = 150;
  localparam int TargetWords = 1750;

  typedef enum logic {RowWord, RowCfg} row_kind_e;

  // One row of the directed table. A row either writes a register or offers
  // one word; where typed is set the expected result is given in the row.
  typedef struct {
    row_kind_e          kind;
    logic [0:0]         cidx;
    logic [CountW-1:0]  cdata;
    logic               mode;
    logic [EntryW-1:0]  ent;
    logic signed [31:0] t;
    logic signed [31:0] v;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] q;
    bit                 typed;
    logic signed [31:0] ev;
    logic               ei;
  } dir_row_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    invalid;
  } curve_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [0:0]              cfg_index;
  logic [CountW-1:0]       cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_mode;
  logic [EntryW-1:0]       in_entry_index;
  logic signed [DataW-1:0] in_knot_time;
  logic signed [DataW-1:0] in_knot_value;
  logic signed [DataW-1:0] in_control_one;
  logic signed [DataW-1:0] in_control_two;
  logic signed [DataW-1:0] in_query_time;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [DataW-1:0] out_curve_value;
  logic                    out_table_invalid;

  piecewise_spline_evaluator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_entry_index(in_entry_index),
    .in_knot_time(in_knot_time), .in_knot_value(in_knot_value),
    .in_control_one(in_control_one), .in_control_two(in_control_two),
    .in_query_time(in_query_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_curve_value(out_curve_value), .out_table_invalid(out_table_invalid)
  );

  // The testbench's own picture of the knot table and the two registers.
  logic signed [31:0] knot_time_m [16];
  logic signed [31:0] knot_value_m [16];
  logic signed [31:0] ctrl_one_m [16];
  logic signed [31:0] ctrl_two_m [16];
  int unsigned        knot_count_m;
  logic [KindW-1:0]   interp_kind_m;

  curve_t pending_curves[$];
  int     errors;
  int     words_sent;
  bit     calm;        // a stretch in which neither side idles
  bit     flood_req;   // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL piecewise_spline_evaluator_unit");
    $finish;
  end

  // Works out the curve value an evaluate word should give, from the
  // testbench's copy of the table and registers.
  function automatic curve_t predict_curve(logic signed [31:0] q);
    curve_t r;
    int     n;
    int     idx;
    int     k;
    bit     ok;
    longint qq, t0, t1, f, u, uu, ff, b0, b1, b2, b3, s, res;
    n = (knot_count_m > 16) ? 16 : int'(knot_count_m);
    ok = (n > 0);
    for (int i = 1; i < n; i++)
      if (knot_time_m[i] <= knot_time_m[i-1]) ok = 1'b0;
    if (!ok) begin
      r.value = '0;
      r.invalid = 1'b1;
      return r;
    end
    qq = longint'(q);
    idx = 0;
    while (idx < n && longint'(knot_time_m[idx]) <= qq) idx++;
    if (idx == 0) begin
      res = longint'(knot_value_m[0]);
    end else if (idx == n) begin
      res = longint'(knot_value_m[n-1]);
    end else begin
      k = idx - 1;
      t0 = longint'(knot_time_m[k]);
      t1 = longint'(knot_time_m[idx]);
      f = ((qq - t0) <<< 16) / (t1 - t0);
      if (f >= 65536) f = 65535;
      u = 65536 - f;
      if (interp_kind_m == KindConst) begin
        res = longint'(knot_value_m[k]);
      end else if (interp_kind_m == KindLinear) begin
        s = longint'(knot_value_m[k]) * u + longint'(knot_value_m[idx]) * f;
        res = (s + 32768) >>> 16;
      end else begin
        // Cubic and the spare kind both take the Bernstein blend.
        uu = (u * u) >>> 16;
        ff = (f * f) >>> 16;
        b0 = (uu * u) >>> 16;
        b1 = 3 * ((uu * f) >>> 16);
        b2 = 3 * ((u * ff) >>> 16);
        b3 = (ff * f) >>> 16;
        s = longint'(knot_value_m[k]) * b0 + longint'(ctrl_one_m[k]) * b1
          + longint'(ctrl_two_m[k]) * b2 + longint'(knot_value_m[idx]) * b3;
        res = (s + 32768) >>> 16;
      end
    end
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.value = res[31:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  // Offers one word, idling at random first, and returns once it is taken.
  // The table copy is updated, or the expected curve queued, on acceptance.
  task automatic send_word(logic mode, logic [3:0] ent, logic signed [31:0] t,
                           logic signed [31:0] v, logic signed [31:0] c1,
                           logic signed [31:0] c2, logic signed [31:0] q,
                           bit typed, curve_t typed_curve);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_entry_index <= ent;
    in_knot_time <= t;
    in_knot_value <= v;
    in_control_one <= c1;
    in_control_two <= c2;
    in_query_time <= q;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (mode == ModeLoad) begin
      knot_time_m[ent] = t;
      knot_value_m[ent] = v;
      ctrl_one_m[ent] = c1;
      ctrl_two_m[ent] = c2;
    end else if (typed) begin
      pending_curves = {pending_curves, typed_curve};
    end else begin
      pending_curves = {pending_curves, predict_curve(q)};
    end
  endtask

  // Lets the block run dry: every expected word back, then an idle stretch
  // of SettleCycles.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_curves.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The write enable drops for a cycle after each write, so back-to-back
  // calls never drive it twice at one edge.
  task automatic write_reg(logic [0:0] idx, logic [CountW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CfgKnotCount) knot_count_m = data;
    else interp_kind_m = data[KindW-1:0];
  endtask

  function automatic logic signed [31:0] rand_word(bit narrow);
    if (narrow) return 32'($urandom_range(0, 1 << 20)) - 32'sd524288;
    return $urandom;
  endfunction

  // Result side: random stalls, a calm stretch and one long hold-off that
  // lets the block fill up and stall its input.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (flood_req && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 17);
      end
    end
  end

  // Checks every taken result word against the oldest expectation.
  always @(posedge clk) begin
    curve_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_curves.size() == 0) begin
        $display("%0t: result word with none expected: value %h invalid %b",
                 $time, out_curve_value, out_table_invalid);
        errors++;
      end else begin
        exp_c = pending_curves.pop_front();
        if (out_curve_value !== exp_c.value) begin
          $display("%0t: curve_value expected %h actual %h",
                   $time, exp_c.value, out_curve_value);
          errors++;
        end
        if (out_table_invalid !== exp_c.invalid) begin
          $display("%0t: table_invalid expected %b actual %b",
                   $time, exp_c.invalid, out_table_invalid);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t           dir_rows [];
    curve_t             tc;
    curve_t             none_c;
    logic signed [31:0] tt [16];
    logic signed [31:0] vv [16];
    longint             base, lo, hi, span, qv;
    int                 eff, cnt, sh, j, k, phase, evals;
    logic [KindW-1:0]   kind;
    logic signed [31:0] q;

    errors = 0;
    words_sent = 0;
    calm = 0;
    flood_req = 0;
    none_c = '{value: '0, invalid: 1'b0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_entry_index = '0;
    in_knot_time = '0;
    in_knot_value = '0;
    in_control_one = '0;
    in_control_two = '0;
    in_query_time = '0;
    foreach (knot_time_m[i]) begin
      knot_time_m[i] = '0;
      knot_value_m[i] = '0;
      ctrl_one_m[i] = '0;
      ctrl_two_m[i] = '0;
    end
    knot_count_m = 1;
    interp_kind_m = KindLinear;

    // Four knots spanning the whole time range, end values at the extremes.
    // The first evaluates run with the reset count of one knot.
    dir_rows = '{
      '{RowWord, CfgKnotCount, 0, ModeLoad, 0, 32'h80000000, 32'h7fffffff,
        32'h80000000, 32'h7fffffff, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeLoad, 1, 32'h00000000, 32'h00010000,
        32'hffffffff, 32'h00000001, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeLoad, 2, 32'h00010000, 32'hfffe0000,
        32'h12345678, 32'hedcba987, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeLoad, 3, 32'h7fffffff, 32'h80000000,
        32'h00000000, 32'h00000000, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h80000000,
        1, 32'h7fffffff, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h7fffffff,
        1, 32'h7fffffff, 0},
      '{RowCfg, CfgKnotCount, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h7fffffff,
        1, 32'h80000000, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h00010000,
        0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h00008000,
        0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h80000001,
        0, 0, 0},
      '{RowCfg, CfgInterpKind, KindConst, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h00004000,
        0, 0, 0},
      '{RowCfg, CfgInterpKind, KindCubic, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h00004000,
        0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h40000000,
        0, 0, 0},
      '{RowCfg, CfgInterpKind, KindSpare, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'hffff0000,
        0, 0, 0},
      // No knots in use: the table counts as invalid.
      '{RowCfg, CfgKnotCount, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h00000000,
        1, 0, 1},
      '{RowCfg, CfgKnotCount, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      // Two equal knot times also make the table invalid.
      '{RowWord, CfgKnotCount, 0, ModeLoad, 2, 32'h00000000, 32'h00000005,
        0, 0, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h00000000,
        1, 0, 1},
      '{RowWord, CfgKnotCount, 0, ModeLoad, 2, 32'h00010000, 32'hfffe0000,
        32'h12345678, 32'hedcba987, 0, 0, 0, 0},
      // A query before the first knot gives the first value.
      '{RowWord, CfgKnotCount, 0, ModeLoad, 0, 32'hfffff000, 32'h7fffffff,
        32'h80000000, 32'h7fffffff, 0, 0, 0, 0},
      '{RowWord, CfgKnotCount, 0, ModeEval, 0, 0, 0, 0, 0, 32'h80000000,
        1, 32'h7fffffff, 0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        settle();
        write_reg(dir_rows[r].cidx, dir_rows[r].cdata);
      end else begin
        tc = '{value: dir_rows[r].ev, invalid: dir_rows[r].ei};
        send_word(dir_rows[r].mode, dir_rows[r].ent, dir_rows[r].t, dir_rows[r].v,
                  dir_rows[r].c1, dir_rows[r].c2, dir_rows[r].q,
                  dir_rows[r].typed, tc);
      end
    end

    // Random phases: new registers, a freshly loaded table (mostly well
    // formed), then a run of evaluates with the odd load word mixed in.
    phase = 0;
    while (words_sent < TargetWords) begin
      settle();
      phase++;
      calm = (words_sent >= 700 && words_sent < 1000);
      case ($urandom_range(9))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = $urandom_range(17, 31);
        3: cnt = 16;
        default: cnt = $urandom_range(2, 16);
      endcase
      kind = $urandom_range(0, 3);
      write_reg(CfgKnotCount, cnt[CountW-1:0]);
      write_reg(CfgInterpKind, CountW'(kind));
      eff = (cnt > 16) ? 16 : cnt;

      if ($urandom_range(1)) begin
        // Knots spread over the full time range, ends sometimes at the limits.
        for (int i = 0; i < 16; i++)
          tt[i] = 32'(-64'sd2147483648 + longint'(i) * (64'sd1 << 28)
                      + longint'($urandom_range(0, (1 << 28) - 1)));
        if ($urandom_range(3) == 0) tt[0] = 32'h80000000;
        if ($urandom_range(3) == 0 && eff > 1) tt[eff-1] = 32'h7fffffff;
      end else begin
        // Closely packed knots, down to unit spacing.
        sh = $urandom_range(0, 20);
        base = longint'($urandom_range(0, 1 << 21)) - (64'sd1 << 20);
        for (int i = 0; i < 16; i++) begin
          tt[i] = 32'(base);
          base += longint'($urandom_range(1, 1 << sh));
        end
      end
      if ($urandom_range(99) < 15 && eff > 1) begin
        j = $urandom_range(1, eff - 1);
        tt[j] = $urandom_range(1) ? tt[j-1] : rand_word(0);
      end
      for (int i = 0; i < eff; i++) begin
        vv[i] = rand_word($urandom_range(1));
        send_word(ModeLoad, i[3:0], tt[i], vv[i], rand_word($urandom_range(1)),
                  rand_word($urandom_range(1)), rand_word(0), 0, none_c);
      end

      if (phase == 8) flood_req = 1;
      evals = (phase == 8) ? 40 : $urandom_range(15, 50);
      for (int e = 0; e < evals; e++) begin
        if ($urandom_range(99) < 5) begin
          k = $urandom_range(0, 15);
          send_word(ModeLoad, k[3:0], (k < eff) ? tt[k] : rand_word(0), rand_word(0),
                    rand_word(0), rand_word(0), rand_word(0), 0, none_c);
          if (k < eff) tt[k] = knot_time_m[k];
        end
        if (eff < 2 || $urandom_range(99) < 10) begin
          q = rand_word(0);
        end else if ($urandom_range(99) < 12) begin
          q = knot_time_m[$urandom_range(0, eff - 1)];
        end else if ($urandom_range(99) < 12) begin
          lo = longint'(knot_time_m[0]);
          hi = longint'(knot_time_m[eff-1]);
          qv = $urandom_range(1) ? lo - longint'($urandom_range(1, 1 << 20))
                                 : hi + longint'($urandom_range(0, 1 << 20));
          if (qv > 64'sd2147483647) qv = 64'sd2147483647;
          if (qv < -64'sd2147483648) qv = -64'sd2147483648;
          q = 32'(qv);
        end else begin
          k = $urandom_range(0, eff - 2);
          lo = longint'(knot_time_m[k]);
          span = longint'(knot_time_m[k+1]) - lo;
          qv = (span > 0) ? lo + (longint'({32'd0, $urandom}) % span) : lo;
          q = 32'(qv);
        end
        send_word(ModeEval, 0, rand_word(0), rand_word(0), rand_word(0),
                  rand_word(0), q, 0, none_c);
      end
    end

    calm = 0;
    settle();
    if (errors == 0) begin
      $display("PASS piecewise_spline_evaluator_unit");
    end else begin
      $display("FAIL piecewise_spline_evaluator_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/pse_pkg.sv
rtl/core/pse_ctrl.sv
rtl/core/pse_dp.sv
rtl/core/piecewise_spline_evaluator_unit.sv
sim/tb_piecewise_spline_evaluator_unit.sv
